[rtl/biquad_iir_filter_df2_core_macros.svh]
// Assertion macros shared by the biquad filter RTL.
`ifndef BIQUAD_IIR_FILTER_DF2_CORE_MACROS_SVH
`define BIQUAD_IIR_FILTER_DF2_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bqdf2_pkg.sv]
// Types, constants, coefficient tables and microcode for the biquad filter.
package bqdf2_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_FRAC  = 16;
    localparam int COEF_W     = COEF_FRAC + 2;
    localparam int STATE_W    = 40;
    localparam int HI_W       = STATE_W - COEF_FRAC;
    localparam int PROD_W     = COEF_W + HI_W;
    localparam int ACC_W      = STATE_W + 4;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    typedef logic [STEP_W-1:0]          step_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    localparam cfg_idx_t REG_FILTER_KIND = 2'd0;
    localparam cfg_idx_t REG_RATE_SELECT = 2'd1;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_FIRST = 4'd1;
    localparam step_t STEP_LAST  = 4'd12;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_ADD,
        ACC_SUB,
        ACC_SAVE_W,
        ACC_FINISH
    } acc_op_t;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OPND_S0,
        OPND_S1,
        OPND_W
    } opnd_sel_t;

    typedef struct packed {
        cond_t     cond;
        step_t     target;
        acc_op_t   acc_op;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        logic      mul_lo;
    } ctrl_word_t;

    typedef struct packed {
        logic      clear;
        logic      fire;
        acc_op_t   acc_op;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        logic      mul_lo;
        logic      kind;
        logic [1:0] rate;
    } dp_ctrl_t;

    // Index is {kind, rate}. b2 equals b0 in every set.
    localparam coef_t COEF_B0_ROM [0:7] = '{
        18'sd8592,  18'sd1826,   18'sd513,    18'sd136,
        18'sd33096, 18'sd50174,  18'sd57356,  18'sd61311
    };
    localparam coef_t COEF_B1_ROM [0:7] = '{
        18'sd17184,   18'sd3652,     18'sd1025,    18'sd273,
        -18'sd66191,  -18'sd100349,  -18'sd114712, -18'sd122621
    };
    // Denominator depends on rate only.
    localparam coef_t COEF_A1_ROM [0:3] = '{
        -18'sd49007, -18'sd96697, -18'sd113687, -18'sd122349
    };
    localparam coef_t COEF_A2_ROM [0:3] = '{
        18'sd17840, 18'sd38464, 18'sd50201, 18'sd57358
    };

    function automatic coef_t coef_lookup(logic kind, logic [1:0] rate, coef_sel_t sel);
        logic [2:0] idx;
        coef_t      v;
        idx = {kind, rate};
        case (sel)
            COEF_B0: v = COEF_B0_ROM[idx];
            COEF_B1: v = COEF_B1_ROM[idx];
            COEF_B2: v = COEF_B0_ROM[idx];
            COEF_A1: v = COEF_A1_ROM[rate];
            COEF_A2: v = COEF_A2_ROM[rate];
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic ctrl_word_t mk(cond_t c, step_t t, acc_op_t op, coef_sel_t cs,
                                      opnd_sel_t os, logic lo);
        ctrl_word_t w;
        w.cond     = c;
        w.target   = t;
        w.acc_op   = op;
        w.coef_sel = cs;
        w.opnd_sel = os;
        w.mul_lo   = lo;
        return w;
    endfunction

    // Each step issues one partial product; the add and subtract steps accumulate the one issued the step before.
    function automatic ctrl_word_t ucode(step_t pc);
        ctrl_word_t w;
        case (pc)
            4'd0:    w = mk(COND_IN,     4'd1,  ACC_LOAD_X, COEF_A1, OPND_S0, 1'b0);
            4'd1:    w = mk(COND_ALWAYS, 4'd2,  ACC_SUB,    COEF_A1, OPND_S0, 1'b1);
            4'd2:    w = mk(COND_ALWAYS, 4'd3,  ACC_SUB,    COEF_A2, OPND_S1, 1'b0);
            4'd3:    w = mk(COND_ALWAYS, 4'd4,  ACC_SUB,    COEF_A2, OPND_S1, 1'b1);
            4'd4:    w = mk(COND_ALWAYS, 4'd5,  ACC_SUB,    COEF_A2, OPND_S1, 1'b1);
            4'd5:    w = mk(COND_ALWAYS, 4'd6,  ACC_SAVE_W, COEF_B1, OPND_S0, 1'b0);
            4'd6:    w = mk(COND_ALWAYS, 4'd7,  ACC_ADD,    COEF_B1, OPND_S0, 1'b1);
            4'd7:    w = mk(COND_ALWAYS, 4'd8,  ACC_ADD,    COEF_B2, OPND_S1, 1'b0);
            4'd8:    w = mk(COND_ALWAYS, 4'd9,  ACC_ADD,    COEF_B2, OPND_S1, 1'b1);
            4'd9:    w = mk(COND_ALWAYS, 4'd10, ACC_ADD,    COEF_B0, OPND_W,  1'b0);
            4'd10:   w = mk(COND_ALWAYS, 4'd11, ACC_ADD,    COEF_B0, OPND_W,  1'b1);
            4'd11:   w = mk(COND_ALWAYS, 4'd12, ACC_ADD,    COEF_B0, OPND_W,  1'b1);
            4'd12:   w = mk(COND_OUT,    4'd0,  ACC_FINISH, COEF_B0, OPND_W,  1'b0);
            default: w = mk(COND_ALWAYS, 4'd0,  ACC_HOLD,   COEF_B0, OPND_S0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

[rtl/bqdf2_if.sv]
// Valid/ready stream interfaces for the filter's sample words.
interface bqdf2_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bqdf2_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqdf2_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bqdf2_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/bqdf2_datapath.sv]
// Biquad datapath: shared multiplier, accumulator, delay states and output rounding.
`include "biquad_iir_filter_df2_core_macros.svh"

module bqdf2_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bqdf2_pkg::dp_ctrl_t                   ctrl,
    input  logic signed [bqdf2_pkg::SAMPLE_W-1:0] x,
    output logic signed [bqdf2_pkg::SAMPLE_W-1:0] y
);

    localparam int SW  = bqdf2_pkg::SAMPLE_W;
    localparam int F   = bqdf2_pkg::COEF_FRAC;
    localparam int STW = bqdf2_pkg::STATE_W;
    localparam int HW  = bqdf2_pkg::HI_W;
    localparam int PW  = bqdf2_pkg::PROD_W;
    localparam int AW  = bqdf2_pkg::ACC_W;
    localparam int RW  = AW - F;

    localparam logic signed [STW-1:0] W_MAX = {1'b0, {(STW-1){1'b1}}};
    localparam logic signed [STW-1:0] W_MIN = {1'b1, {(STW-1){1'b0}}};
    localparam logic signed [SW-1:0]  Y_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]  Y_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [AW-1:0]  ROUND_HALF = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [STW-1:0] s0_reg, s0_next;
    logic signed [STW-1:0] s1_reg, s1_next;
    logic signed [STW-1:0] w_reg,  w_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic                  prod_lo_reg;

    bqdf2_pkg::coef_t      mul_a;
    logic signed [STW-1:0] opnd;
    logic signed [HW-1:0]  mul_b;
    logic signed [PW-1:0]  prod_shf;
    logic signed [AW-1:0]  term;
    logic signed [AW-1:0]  acc_rnd;
    logic signed [RW-1:0]  y_wide;
    logic                  w_fits;
    logic                  y_fits;

    // Operand is split into a signed high part and an unsigned low part of F bits.
    always_comb
    begin
        mul_a = bqdf2_pkg::coef_lookup(ctrl.kind, ctrl.rate, ctrl.coef_sel);
        case (ctrl.opnd_sel)
            bqdf2_pkg::OPND_S0: opnd = s0_reg;
            bqdf2_pkg::OPND_S1: opnd = s1_reg;
            bqdf2_pkg::OPND_W:  opnd = w_reg;
            default:            opnd = s0_reg;
        endcase
        if (ctrl.mul_lo)
            mul_b = {{(HW-F){1'b0}}, opnd[F-1:0]};
        else
            mul_b = opnd[STW-1:F];
        prod_next = mul_a * mul_b;
    end

    // Low-part products are floored to F fraction bits.
    always_comb
    begin
        prod_shf = prod_lo_reg ? (prod_reg >>> F) : prod_reg;
        term     = {{(AW-PW){prod_shf[PW-1]}}, prod_shf};
    end

    always_comb
    begin
        w_fits  = (acc_reg[AW-1:STW-1] == '0) || (acc_reg[AW-1:STW-1] == '1);
        acc_rnd = acc_reg + ROUND_HALF;
        y_wide  = acc_rnd[AW-1:F];
        y_fits  = (y_wide[RW-1:SW-1] == '0) || (y_wide[RW-1:SW-1] == '1);
        if (y_fits)
            y = y_wide[SW-1:0];
        else if (y_wide[RW-1])
            y = Y_MIN;
        else
            y = Y_MAX;
    end

    always_comb
    begin
        acc_next = acc_reg;
        w_next   = w_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        if (ctrl.fire)
        begin
            case (ctrl.acc_op)
                bqdf2_pkg::ACC_LOAD_X: acc_next = {{(AW-SW-F){x[SW-1]}}, x, {F{1'b0}}};
                bqdf2_pkg::ACC_ADD:    acc_next = acc_reg + term;
                bqdf2_pkg::ACC_SUB:    acc_next = acc_reg - term;
                bqdf2_pkg::ACC_SAVE_W:
                begin
                    acc_next = '0;
                    if (w_fits)
                        w_next = acc_reg[STW-1:0];
                    else if (acc_reg[AW-1])
                        w_next = W_MIN;
                    else
                        w_next = W_MAX;
                end
                bqdf2_pkg::ACC_FINISH:
                begin
                    s1_next = s0_reg;
                    s0_next = w_reg;
                end
                default:               acc_next = acc_reg;
            endcase
        end
        // A new coefficient set restarts the filter.
        if (ctrl.clear)
        begin
            s0_next = '0;
            s1_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        w_reg   <= w_next;
        if (ctrl.fire)
        begin
            prod_reg    <= prod_next;
            prod_lo_reg <= ctrl.mul_lo;
        end
    end

    `BQ_ASSERT_NXT(a_clear_zeroes_state, ctrl.clear, (s0_reg == '0) && (s1_reg == '0), "delay states not cleared on config write")
    `BQ_ASSERT_NXT(a_delay_shift, ctrl.fire && (ctrl.acc_op == bqdf2_pkg::ACC_FINISH) && !ctrl.clear, (s1_reg == $past(s0_reg)) && (s0_reg == $past(w_reg)), "delay line did not shift")

endmodule

[rtl/biquad_iir_filter_df2_core.sv]
// Biquad IIR filter core: microcoded sequencer, config registers and output word register.
// Second-order Butterworth IIR in direct form II. One signed 16-bit sample word in gives one
// filtered word out. A sample is taken when the sequencer sits at its idle step; the word
// then runs through a 13-step program (idle step included) held in a ROM, which
// drives one shared 18x24 multiplier through ten partial products (each coefficient times
// the high and low parts of a 40-bit state). The last step waits while the previous result
// is still unread in the output register. Writing filter_kind (index 0) or rate_select
// (index 1) selects one of eight coefficient sets and clears both delay states; other
// indexes are ignored. Write configuration only while no sample is in flight.
`include "biquad_iir_filter_df2_core_macros.svh"

module biquad_iir_filter_df2_core (
    input  logic                                clk,
    input  logic                                rst_n,
    bqdf2_in_if.sink                            samples,
    bqdf2_out_if.source                         filtered,
    input  logic                                cfg_wr_en,
    input  logic [bqdf2_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqdf2_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW = bqdf2_pkg::SAMPLE_W;

    bqdf2_pkg::step_t      pc_reg, pc_next;
    bqdf2_pkg::ctrl_word_t cw;
    bqdf2_pkg::dp_ctrl_t   dp_ctrl;
    logic                  kind_reg;
    logic [1:0]            rate_reg;
    logic                  out_valid_reg;
    logic signed [SW-1:0]  out_data_reg;
    logic signed [SW-1:0]  y;
    logic                  fire;
    logic                  cfg_hit;

    assign cw = bqdf2_pkg::ucode(pc_reg);

    always_comb
    begin
        case (cw.cond)
            bqdf2_pkg::COND_ALWAYS: fire = 1'b1;
            bqdf2_pkg::COND_IN:     fire = samples.valid;
            bqdf2_pkg::COND_OUT:    fire = !out_valid_reg || filtered.ready;
            default:                fire = 1'b1;
        endcase
        pc_next = fire ? cw.target : pc_reg;
    end

    assign samples.ready    = (cw.cond == bqdf2_pkg::COND_IN);
    assign filtered.valid   = out_valid_reg;
    assign filtered.sample_out = out_data_reg;

    assign cfg_hit = cfg_wr_en && ((cfg_index == bqdf2_pkg::REG_FILTER_KIND) ||
                                   (cfg_index == bqdf2_pkg::REG_RATE_SELECT));

    always_comb
    begin
        dp_ctrl.clear    = cfg_hit;
        dp_ctrl.fire     = fire;
        dp_ctrl.acc_op   = cw.acc_op;
        dp_ctrl.coef_sel = cw.coef_sel;
        dp_ctrl.opnd_sel = cw.opnd_sel;
        dp_ctrl.mul_lo   = cw.mul_lo;
        dp_ctrl.kind     = kind_reg;
        dp_ctrl.rate     = rate_reg;
    end

    bqdf2_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dp_ctrl),
        .x     (samples.sample_in),
        .y     (y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= bqdf2_pkg::STEP_IDLE;
            kind_reg      <= 1'b0;
            rate_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_wr_en && (cfg_index == bqdf2_pkg::REG_FILTER_KIND))
                kind_reg <= cfg_data[0];
            if (cfg_wr_en && (cfg_index == bqdf2_pkg::REG_RATE_SELECT))
                rate_reg <= cfg_data[1:0];
            if (fire && (cw.acc_op == bqdf2_pkg::ACC_FINISH))
                out_valid_reg <= 1'b1;
            else if (filtered.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (cw.acc_op == bqdf2_pkg::ACC_FINISH))
            out_data_reg <= y;
    end

    `BQ_ASSERT_NXT(a_accept_starts_program, samples.valid && samples.ready, pc_reg == bqdf2_pkg::STEP_FIRST, "program did not start on accepted word")
    `BQ_ASSERT_IMP(a_result_from_last_step, $rose(filtered.valid), $past(pc_reg) == bqdf2_pkg::STEP_LAST, "result word not produced by the last step")

endmodule

[tb/biquad_iir_filter_df2_core_test.sv]
// Self-checking testbench for the biquad core: random and directed sample words, own predictor.
`timescale 1ns / 1ps

module biquad_iir_filter_df2_core_test;

    localparam int SAMPLE_W   = bqdf2_pkg::SAMPLE_W;
    localparam int COEF_FRAC  = bqdf2_pkg::COEF_FRAC;
    localparam int STATE_W    = bqdf2_pkg::STATE_W;
    localparam int CFG_DATA_W = bqdf2_pkg::CFG_DATA_W;

    // Indexes with no register behind them
    localparam bqdf2_pkg::cfg_idx_t REG_UNMAPPED_LO = 2'd2;
    localparam bqdf2_pkg::cfg_idx_t REG_UNMAPPED_HI = 2'd3;

    localparam longint FRAC_ONE  = longint'(1) <<< COEF_FRAC;
    localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint OUT_MAX   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;

    localparam int HOLD_LEN = 150;

    // Butterworth sets in units of 1e-8, numerator indexed by {kind, rate}
    localparam longint B0_DEC [0:7] = '{
        13110644, 2785977, 782021, 208057, 50500103, 76559999, 87518309, 93552671
    };
    localparam longint B1_DEC [0:7] = '{
        26221288, 5571953, 1564042, 416113,
        -101000206, -153119998, -175036618, -187105341
    };
    localparam longint A1_DEC [0:3] = '{-74778918, -147548044, -173472577, -186689228};
    localparam longint A2_DEC [0:3] = '{27221494, 58691951, 76600660, 87521455};

    typedef enum {SHAPE_NOISE, SHAPE_STEP, SHAPE_TOGGLE, SHAPE_SMALL} shape_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    bqdf2_pkg::cfg_idx_t       cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    bqdf2_in_if  samples_bus ();
    bqdf2_out_if filtered_bus ();

    // predictor state
    logic                  filt_kind = 1'b0;
    logic [1:0]            rate_sel  = 2'd0;
    longint                state_s0  = 0;
    longint                state_s1  = 0;

    logic signed [SAMPLE_W-1:0] samples_to_send [$];
    logic signed [SAMPLE_W-1:0] expected_outputs [$];
    int                    accept_count = 0;
    int                    offer_seen = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    logic                  hold_active = 1'b0;
    event                  hold_go;
    int                    mismatch_count = 0;

    biquad_iir_filter_df2_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_bus),
        .filtered  (filtered_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round(|c| * 2^F) with ties away from zero
    function automatic longint coef_q16(longint dec);
        longint mag;
        mag = (dec < 0) ? -dec : dec;
        mag = (mag * FRAC_ONE + 50_000_000) / 100_000_000;
        return (dec < 0) ? -mag : mag;
    endfunction

    function automatic void apply_config(bqdf2_pkg::cfg_idx_t idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            bqdf2_pkg::REG_FILTER_KIND:
            begin
                filt_kind = data[0];
                state_s0  = 0;
                state_s1  = 0;
            end
            bqdf2_pkg::REG_RATE_SELECT:
            begin
                rate_sel = data[1:0];
                state_s0 = 0;
                state_s1 = 0;
            end
            default: ;
        endcase
    endfunction

    // One DF2 step; products are floored to F fraction bits
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        logic signed [SAMPLE_W-1:0] x);
        int     sel;
        longint b0, b1, b2, a1, a2, w, y, r;
        sel = int'({filt_kind, rate_sel});
        b0 = coef_q16(B0_DEC[sel]);
        b1 = coef_q16(B1_DEC[sel]);
        b2 = b0;   // numerator is symmetric in every set
        a1 = coef_q16(A1_DEC[rate_sel]);
        a2 = coef_q16(A2_DEC[rate_sel]);
        w = longint'(x) * FRAC_ONE - ((a1 * state_s0) >>> COEF_FRAC)
            - ((a2 * state_s1) >>> COEF_FRAC);
        if (w > STATE_MAX)
            w = STATE_MAX;
        else if (w < STATE_MIN)
            w = STATE_MIN;
        y = ((b0 * w) >>> COEF_FRAC) + ((b1 * state_s0) >>> COEF_FRAC)
            + ((b2 * state_s1) >>> COEF_FRAC);
        r = (y + FRAC_ONE / 2) >>> COEF_FRAC;
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < OUT_MIN)
            r = OUT_MIN;
        state_s1 = state_s0;
        state_s0 = w;
        return r[SAMPLE_W-1:0];
    endfunction

    task automatic write_reg(bqdf2_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_run(logic signed [SAMPLE_W-1:0] word, int count);
        repeat (count) samples_to_send.push_back(word);
    endtask

    // Checked just after a falling edge, once the sender has settled
    task automatic drain_outputs();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (samples_to_send.size() != 0 || samples_bus.valid
               || expected_outputs.size() != 0);
    endtask

    // Sender: holds a word until taken, then maybe offers the next one
    always @(negedge clk)
    begin : drive_samples
        logic                       offer;
        logic signed [SAMPLE_W-1:0] next_word;
        offer      = samples_bus.valid && (accept_count == offer_seen);
        offer_seen = accept_count;
        if (rst_n)
        begin
            next_word = samples_bus.sample_in;
            if (!offer && samples_to_send.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = samples_to_send.pop_front();
                offer     = 1'b1;
            end
            samples_bus.valid     <= offer;
            samples_bus.sample_in <= next_word;
        end
        else
        begin
            samples_bus.valid     <= 1'b0;
            samples_bus.sample_in <= '0;
        end
    end

    // Long receiver hold-off, counted here
    always
    begin : hold_off
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_active = 1'b0;
    end

    // Receiver: random stalls, plus the long hold-off when active
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (hold_active)
                filtered_bus.ready <= 1'b0;
            else
                filtered_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        else
            filtered_bus.ready <= 1'b0;
    end

    always @(posedge clk)
    begin : watch_ports
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                apply_config(cfg_index, cfg_data);
            if (samples_bus.valid && samples_bus.ready)
            begin
                expected_outputs.push_back(filter_sample(samples_bus.sample_in));
                accept_count++;
            end
            if (filtered_bus.valid && filtered_bus.ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: sample_out expected none, actual %0d", $time,
                             filtered_bus.sample_out);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (filtered_bus.sample_out !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: sample_out expected %0d, actual %0d", $time,
                                 want, filtered_bus.sample_out);
                    end
                end
            end
        end
    end

    initial
    begin
        shape_t                     shape;
        logic signed [SAMPLE_W-1:0] word;
        int                         run_left;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = bqdf2_pkg::REG_FILTER_KIND;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: lowpass at the slowest rate, extremes and step overshoot
        write_reg(bqdf2_pkg::REG_FILTER_KIND, 2'd0);
        write_reg(bqdf2_pkg::REG_RATE_SELECT, 2'd0);
        queue_run(16'sd0, 1);
        queue_run(16'sd1, 1);
        queue_run(-16'sd1, 1);
        queue_run(16'sh7FFF, 6);
        queue_run(16'sh8000, 4);
        drain_outputs();
        // unmapped indexes must leave the delay line alone
        write_reg(REG_UNMAPPED_LO, 2'd3);
        write_reg(REG_UNMAPPED_HI, 2'd1);
        queue_run(16'sd100, 1);
        queue_run(-16'sd100, 1);
        drain_outputs();
        // upper data bit is dropped: highpass, fastest rate
        write_reg(bqdf2_pkg::REG_FILTER_KIND, 2'd3);
        write_reg(bqdf2_pkg::REG_RATE_SELECT, 2'd3);
        for (int n = 0; n < 6; n++)
            samples_to_send.push_back(n[0] ? 16'sh8000 : 16'sh7FFF);
        queue_run(16'sh5555, 1);
        queue_run(16'shAAAA, 1);
        drain_outputs();

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_reg(bqdf2_pkg::REG_FILTER_KIND, {1'($urandom), 1'(seg[0])});
            write_reg(bqdf2_pkg::REG_RATE_SELECT, 2'(seg >> 1));
            run_left = 0;
            for (int n = 0; n < 75; n++)
            begin
                if (run_left == 0)
                begin
                    shape    = shape_t'($urandom_range(3));
                    run_left = int'($urandom_range(30, 1));
                    word     = 16'($urandom);
                    if (shape == SHAPE_STEP && $urandom_range(1))
                        word = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end
                case (shape)
                    SHAPE_NOISE:  word = 16'($urandom);
                    SHAPE_STEP:   ;
                    SHAPE_TOGGLE: word = run_left[0] ? 16'sh7FFF : 16'sh8000;
                    default:      word = 16'($urandom_range(512) - 256);
                endcase
                samples_to_send.push_back(word);
                run_left--;
            end
            // long receiver hold-off while the sender keeps pushing
            if (seg == 0)
                -> hold_go;
            drain_outputs();
        end

        repeat (26) @(posedge clk);
        if (mismatch_count == 0)
            $display("biquad_iir_filter_df2_core_test: clean");
        else
            $display("biquad_iir_filter_df2_core_test: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("biquad_iir_filter_df2_core_test: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bqdf2_pkg.sv
rtl/bqdf2_if.sv
rtl/bqdf2_datapath.sv
rtl/biquad_iir_filter_df2_core.sv
tb/biquad_iir_filter_df2_core_test.sv
